FILE: src/wildcard_byte_pattern_search_macros.svh
// Assertion macros for the wildcard byte pattern search block
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/wbps_pkg.sv
// Package for the wildcard byte pattern search: widths and register map
package wbps_pkg;

  localparam int AddrW    = 48;
  localparam int ByteW    = 8;
  localparam int PatBytes = 16;
  localparam int LenRegW  = 5;
  localparam int MaskW    = 16;
  localparam int DataW    = 64;
  localparam int PaddrW   = 6;
  localparam int RegIdxW  = 3;

  localparam logic [AddrW-1:0] AddrMax = {AddrW{1'b1}};

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  localparam reg_idx_t REG_PATTERN_LOW  = 3'd0;
  localparam reg_idx_t REG_PATTERN_HIGH = 3'd1;
  localparam reg_idx_t REG_CARE_MASK    = 3'd2;
  localparam reg_idx_t REG_PATTERN_LEN  = 3'd3;
  localparam reg_idx_t REG_BASE_ADDR    = 3'd4;

endpackage

FILE: src/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search: masked window compare over a byte stream
//
//   channel   | direction | handshake                  | payload
//   item      | in        | item_valid / item_stall    | data_byte, last_in_range
//   result    | out       | result_valid / result_stall| found, match_address
//   config    | in/out    | APB (psel, penable, ...)   | paddr, pwdata, prdata
//
// One byte is taken every cycle unless item_stall is high; a byte passes an
// input register and the window compare, and its result (last byte only) is
// then loaded into the result register. The window compare plus the address add
// set the cycle. Reset is synchronous and needs no clearing pass. The item side
// stalls only when a last byte waits at the compare while the result register
// still holds an untaken result under result_stall.
`include "wildcard_byte_pattern_search_macros.svh"

module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [ByteW-1:0]    data_byte,
  input  logic                last_in_range,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                found,
  output logic [AddrW-1:0]    match_address,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  localparam int LenW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CmpW = (LenW > LenRegW) ? LenW : LenRegW;
  localparam int IdxW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  // configuration registers
  logic [DataW-1:0]   pattern_low_bytes;
  logic [DataW-1:0]   pattern_high_bytes;
  logic [MaskW-1:0]   care_mask;
  logic [LenRegW-1:0] pattern_length;
  addr_t              base_address;

  // input register
  logic  item_q_valid;
  byte_t data_q;
  logic  last_q;

  // scan state
  byte_t window [MAX_PATTERN_BYTES];
  byte_t win_next [MAX_PATTERN_BYTES];
  addr_t bytes_seen;
  addr_t bytes_seen_next;
  logic  match_seen;
  addr_t hit_address;

  // compare
  byte_t            pat_byte [PatBytes];
  logic [CmpW-1:0]  len_wide;
  logic [LenW-1:0]  len_eff;
  logic [IdxW-1:0]  len_m1;
  logic [IdxW-1:0]  tap_idx [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] pos_ok;
  logic             cand;
  addr_t            cand_addr;
  logic             match_now;
  addr_t            addr_now;

  logic advance;
  logic proc_fire;
  logic end_fire;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      care_mask          <= '0;
      pattern_length     <= LenRegW'(1);
      base_address       <= '0;
    end else if (cfg_write) begin
      case (paddr[PaddrW-1 -: RegIdxW])
        REG_PATTERN_LOW:  pattern_low_bytes  <= pwdata;
        REG_PATTERN_HIGH: pattern_high_bytes <= pwdata;
        REG_CARE_MASK:    care_mask          <= pwdata[MaskW-1:0];
        REG_PATTERN_LEN:  pattern_length     <= pwdata[LenRegW-1:0];
        REG_BASE_ADDR:    base_address       <= pwdata[AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PaddrW-1 -: RegIdxW])
      REG_PATTERN_LOW:  prdata = pattern_low_bytes;
      REG_PATTERN_HIGH: prdata = pattern_high_bytes;
      REG_CARE_MASK:    prdata = DataW'(care_mask);
      REG_PATTERN_LEN:  prdata = DataW'(pattern_length);
      REG_BASE_ADDR:    prdata = DataW'(base_address);
      default:          prdata = '0;
    endcase
  end

  // hold a last byte at the compare while the result register is blocked
  assign advance    = !(item_q_valid && last_q && result_valid && result_stall);
  assign item_stall = !advance;
  assign proc_fire  = item_q_valid && advance;
  assign end_fire   = proc_fire && last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (advance) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      data_q <= data_byte;
      last_q <= last_in_range;
    end
  end

  // effective length, clamped to one .. MAX_PATTERN_BYTES
  always_comb begin
    len_wide = CmpW'(pattern_length);
    if (len_wide == '0) begin
      len_eff = LenW'(1);
    end else if (len_wide > CmpW'(MAX_PATTERN_BYTES)) begin
      len_eff = LenW'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = LenW'(len_wide);
    end
    len_m1 = IdxW'(len_eff - LenW'(1));
  end

  always_comb begin
    for (int i = 0; i < PatBytes; i++) begin
      if (i < 8) begin
        pat_byte[i] = pattern_low_bytes[8*i +: ByteW];
      end else begin
        pat_byte[i] = pattern_high_bytes[8*(i-8) +: ByteW];
      end
    end
  end

  always_comb begin
    win_next[0] = data_q;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      win_next[k] = window[k-1];
    end
  end

  // pattern byte i lines up with the window tap of age len-1-i
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      tap_idx[i] = len_m1 - IdxW'(i);
      if (LenW'(i) >= len_eff) begin
        pos_ok[i] = 1'b1;
      end else if (i >= PatBytes) begin
        pos_ok[i] = 1'b1;
      end else if (!care_mask[4'(i)]) begin
        pos_ok[i] = 1'b1;
      end else begin
        pos_ok[i] = (pat_byte[4'(i)] == win_next[tap_idx[i]]);
      end
    end
  end

  always_comb begin
    bytes_seen_next = (bytes_seen == AddrMax) ? bytes_seen : bytes_seen + AddrW'(1);
    cand      = (&pos_ok) && (bytes_seen_next >= AddrW'(len_eff));
    cand_addr = base_address + bytes_seen_next - AddrW'(len_eff);
    match_now = match_seen || cand;
    addr_now  = match_seen ? hit_address : cand_addr;
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window[k] <= win_next[k];
      end
      if (!match_seen) begin
        hit_address <= cand_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
    end else if (end_fire) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
    end else if (proc_fire) begin
      bytes_seen <= bytes_seen_next;
      match_seen <= match_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (end_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) begin
      found         <= match_now;
      match_address <= match_now ? addr_now : '0;
    end
  end

  `WBPS_ASSERT_NEXT(a_end_loads_result, end_fire, result_valid,
    "end of range did not load the result register")
  `WBPS_ASSERT_NEXT(a_end_clears_scan, end_fire, (bytes_seen == '0) && !match_seen,
    "scan state not cleared after end of range")
  `WBPS_ASSERT_NEXT(a_match_held, match_seen && !end_fire, match_seen,
    "match flag dropped inside a range")
  `WBPS_ASSERT_NOW(a_no_match_zero_addr, result_valid && !found, match_address == '0,
    "non-zero address reported without a match")

endmodule
